// ----- rtl/core/bba_pkg.sv -----
// shared types, widths and codes of the buddy block allocator
package bba_pkg;

  localparam int ADDR_W    = 48;
  localparam int BYTES_W   = 17;
  localparam int CNT_W     = 13;
  localparam int STAT_W    = 2;
  localparam int ORD_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_FIT  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL = 1'b1;

  localparam logic [BYTES_W-1:0] POOL_RESET = 17'h10000;

  typedef enum logic [1:0] {
    NODE_ABSENT = 2'd0,
    NODE_FREE   = 2'd1,
    NODE_ALLOC  = 2'd2,
    NODE_SPLIT  = 2'd3
  } node_e;

  // position of the highest set bit, zero for zero
  function automatic logic [ORD_W-1:0] msb_pos(input logic [BYTES_W-1:0] v);
    logic [ORD_W-1:0] r;
    r = '0;
    for (int i = 0; i < BYTES_W; i++) begin
      if (v[i]) r = ORD_W'(i);
    end
    return r;
  endfunction

  // block size in bytes, wrapped to the field width
  function automatic logic [BYTES_W-1:0] pow2_bytes(input logic [ORD_W-1:0] o);
    return BYTES_W'(1) << o;
  endfunction

endpackage

// ----- rtl/core/bba_req_if.sv -----
// request channel of the buddy block allocator
interface bba_req_if import bba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [BYTES_W-1:0] request_bytes;
  logic [ADDR_W-1:0]  address;

  modport source (output valid, command, request_bytes, address, input ready);
  modport sink   (input valid, command, request_bytes, address, output ready);
endinterface

// ----- rtl/core/bba_rsp_if.sv -----
// result channel of the buddy block allocator
interface bba_rsp_if import bba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [ADDR_W-1:0]  block_address;
  logic [BYTES_W-1:0] allocated_bytes;
  logic [BYTES_W-1:0] free_bytes;
  logic [CNT_W-1:0]   allocated_blocks;
  logic [CNT_W-1:0]   free_blocks;

  modport source (output valid, status, block_address, allocated_bytes, free_bytes,
                  allocated_blocks, free_blocks, input ready);
  modport sink   (input valid, status, block_address, allocated_bytes, free_bytes,
                  allocated_blocks, free_blocks, output ready);
endinterface

// ----- rtl/core/bba_tree_ram.sv -----
// single port pair tree node memory with registered read
module bba_tree_ram #(
  parameter int AW = 13,
  parameter int DW = 7
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);
  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
endmodule

// ----- rtl/core/bba_ctrl.sv -----
// allocator sequencer: tree walks, totals and result register
module bba_ctrl import bba_pkg::*; #(
  parameter int MIN_BLOCK_ORDER = 4,
  parameter int POOL_ORDER_MAX  = 16,
  parameter int IW              = 13,
  parameter int EW              = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  bba_req_if.sink              req_i,
  bba_rsp_if.source            rsp_o,
  output logic                 mem_rd_en_o,
  output logic [IW-1:0]        mem_rd_addr_o,
  input  logic [EW-1:0]        mem_rd_data_i,
  output logic                 mem_wr_en_o,
  output logic [IW-1:0]        mem_wr_addr_o,
  output logic [EW-1:0]        mem_wr_data_o
);
  localparam int OFS_W = POOL_ORDER_MAX;
  localparam logic [ORD_W-1:0] MIN_ORD = ORD_W'(MIN_BLOCK_ORDER);
  localparam logic [ORD_W-1:0] MAX_ORD = ORD_W'(POOL_ORDER_MAX);
  localparam logic [IW-1:0]    ROOT    = IW'(1);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DEC, ST_CHK, ST_A_EVAL, ST_A_SPLITR, ST_A_LEFT,
    ST_F_EVAL, ST_UP_RD, ST_UP_EVAL, ST_FIN
  } state_e;

  state_e             state_q;
  logic [ADDR_W-1:0]  base_q;
  logic [BYTES_W-1:0] pool_q;
  logic [ORD_W-1:0]   top_q;
  logic               cmd_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [ADDR_W-1:0]  off_q;
  logic               below_q;
  logic [ORD_W-1:0]   req_q;
  logic [IW-1:0]      idx_q;
  logic [ORD_W-1:0]   ord_q;
  logic [OFS_W-1:0]   start_q;
  logic               vfree_q;
  logic               merge_q;
  logic [ORD_W-1:0]   cur_av_q;
  logic [STAT_W-1:0]  stat_q;
  logic [ADDR_W-1:0]  blk_q;
  logic [BYTES_W-1:0] alloc_bytes_q, free_bytes_q;
  logic [CNT_W-1:0]   alloc_blocks_q, free_blocks_q;
  logic               out_valid_q;

  logic [ORD_W-1:0]   top_calc, pool_msb, ceil_ord, req_calc;
  node_e              ent_st;
  logic [ORD_W-1:0]   ent_av, up_max;
  logic [IW-1:0]      idx_l, idx_r, idx_sib, idx_par;
  logic               a_free, chk_bad;
  logic [ORD_W-1:0]   ord_dn;
  logic [OFS_W-1:0]   half;

  // top order from the configured pool size
  assign pool_msb = msb_pos(pool_q);
  always_comb begin
    top_calc = pool_msb;
    if (top_calc < MIN_ORD) top_calc = MIN_ORD;
    if (top_calc > MAX_ORD) top_calc = MAX_ORD;
  end

  // request rounded up to an order
  assign ceil_ord = (bytes_q == BYTES_W'(1)) ? '0 : msb_pos(bytes_q - BYTES_W'(1)) + ORD_W'(1);
  assign req_calc = (ceil_ord < MIN_ORD) ? MIN_ORD : ceil_ord;

  assign ent_st  = node_e'(mem_rd_data_i[EW-1 -: 2]);
  assign ent_av  = mem_rd_data_i[ORD_W-1:0];
  assign idx_l   = {idx_q[IW-2:0], 1'b0};
  assign idx_r   = {idx_q[IW-2:0], 1'b1};
  assign idx_sib = {idx_q[IW-1:1], ~idx_q[0]};
  assign idx_par = {1'b0, idx_q[IW-1:1]};
  assign a_free  = vfree_q || (ent_st == NODE_FREE);
  assign ord_dn  = ord_q - ORD_W'(1);
  assign half    = OFS_W'(1) << ord_dn;
  assign up_max  = (ent_av > cur_av_q) ? ent_av : cur_av_q;
  assign chk_bad = below_q || (off_q >= ADDR_W'(pool_q)) || (off_q >= (ADDR_W'(1) << top_q));

  // memory port control
  always_comb begin
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = idx_q;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = idx_q;
    mem_wr_data_o = '0;
    case (state_q)
      ST_INIT: begin
        mem_wr_en_o   = 1'b1;
        mem_wr_addr_o = ROOT;
        mem_wr_data_o = {NODE_FREE, top_calc + ORD_W'(1)};
      end
      ST_DEC: begin
        if (cmd_q == CMD_ALLOC && bytes_q != '0 && ceil_ord <= top_q) begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = ROOT;
        end
      end
      ST_CHK: begin
        if (!chk_bad) begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = ROOT;
        end
      end
      ST_A_EVAL: begin
        if (a_free && ord_q == req_q) begin
          mem_wr_en_o   = 1'b1;
          mem_wr_data_o = {NODE_ALLOC, ORD_W'(0)};
        end else if (a_free) begin
          mem_wr_en_o   = 1'b1;
          mem_wr_data_o = {NODE_SPLIT, ORD_W'(0)};
        end else if (ent_st == NODE_SPLIT && ent_av > req_q) begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = idx_l;
        end
      end
      ST_A_SPLITR: begin
        mem_wr_en_o   = 1'b1;
        mem_wr_addr_o = idx_r;
        mem_wr_data_o = {NODE_FREE, ord_q};
      end
      ST_A_LEFT: begin
        if (!(ent_av > req_q)) begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = idx_r;
        end
      end
      ST_F_EVAL: begin
        if (ent_st == NODE_ALLOC) begin
          if (off_q[OFS_W-1:0] == start_q) begin
            mem_wr_en_o   = 1'b1;
            mem_wr_data_o = {NODE_FREE, ord_q + ORD_W'(1)};
          end
        end else if (ent_st == NODE_SPLIT && ord_q > MIN_ORD) begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = off_q[ord_dn] ? idx_r : idx_l;
        end
      end
      ST_UP_RD: begin
        if (idx_q != ROOT) begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = idx_sib;
        end
      end
      ST_UP_EVAL: begin
        mem_wr_en_o   = 1'b1;
        mem_wr_addr_o = idx_par;
        if (merge_q && ent_st == NODE_FREE) begin
          mem_wr_data_o = {NODE_FREE, ord_q + ORD_W'(2)};
        end else begin
          mem_wr_data_o = {NODE_SPLIT, up_max};
        end
      end
      default: ;
    endcase
  end

  assign req_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_INIT;
      base_q         <= '0;
      pool_q         <= POOL_RESET;
      top_q          <= MIN_ORD;
      idx_q          <= ROOT;
      alloc_bytes_q  <= '0;
      free_bytes_q   <= '0;
      alloc_blocks_q <= '0;
      free_blocks_q  <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (out_valid_q && rsp_o.ready && state_q != ST_FIN) out_valid_q <= 1'b0;
      case (state_q)
        ST_INIT: begin
          top_q          <= top_calc;
          alloc_bytes_q  <= '0;
          free_bytes_q   <= pow2_bytes(top_calc);
          alloc_blocks_q <= '0;
          free_blocks_q  <= CNT_W'(1);
          state_q        <= ST_IDLE;
        end
        ST_IDLE: begin
          if (cfg_we_i) begin
            if (cfg_idx_i == CFG_BASE) base_q <= cfg_data_i;
            else pool_q <= cfg_data_i[BYTES_W-1:0];
            state_q <= ST_INIT;
          end else if (req_i.valid) begin
            cmd_q   <= req_i.command;
            bytes_q <= req_i.request_bytes;
            addr_q  <= req_i.address;
            state_q <= ST_DEC;
          end
        end
        ST_DEC: begin
          off_q   <= addr_q - base_q;
          below_q <= addr_q < base_q;
          blk_q   <= '0;
          idx_q   <= ROOT;
          ord_q   <= top_q;
          start_q <= '0;
          vfree_q <= 1'b0;
          req_q   <= req_calc;
          if (cmd_q == CMD_FREE) begin
            state_q <= ST_CHK;
          end else if (bytes_q == '0) begin
            stat_q  <= STAT_IGNORED;
            state_q <= ST_FIN;
          end else if (ceil_ord > top_q) begin
            stat_q  <= STAT_NO_FIT;
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_A_EVAL;
          end
        end
        ST_CHK: begin
          if (chk_bad) begin
            stat_q  <= STAT_IGNORED;
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_F_EVAL;
          end
        end
        ST_A_EVAL: begin
          if (a_free && ord_q == req_q) begin
            free_blocks_q  <= free_blocks_q - CNT_W'(1);
            free_bytes_q   <= free_bytes_q - pow2_bytes(req_q);
            alloc_blocks_q <= alloc_blocks_q + CNT_W'(1);
            alloc_bytes_q  <= alloc_bytes_q + pow2_bytes(req_q);
            blk_q          <= base_q + ADDR_W'(start_q);
            stat_q         <= STAT_DONE;
            cur_av_q       <= '0;
            merge_q        <= 1'b0;
            state_q        <= ST_UP_RD;
          end else if (a_free) begin
            free_blocks_q <= free_blocks_q + CNT_W'(1);
            state_q       <= ST_A_SPLITR;
          end else if (ent_st == NODE_SPLIT && ent_av > req_q) begin
            state_q <= ST_A_LEFT;
          end else begin
            stat_q  <= STAT_NO_FIT;
            state_q <= ST_FIN;
          end
        end
        ST_A_SPLITR: begin
          idx_q   <= idx_l;
          ord_q   <= ord_dn;
          vfree_q <= 1'b1;
          state_q <= ST_A_EVAL;
        end
        ST_A_LEFT: begin
          // read data still holds the left child when it is taken
          ord_q   <= ord_dn;
          vfree_q <= 1'b0;
          state_q <= ST_A_EVAL;
          if (ent_av > req_q) begin
            idx_q <= idx_l;
          end else begin
            idx_q   <= idx_r;
            start_q <= start_q + half;
          end
        end
        ST_F_EVAL: begin
          if (ent_st == NODE_ALLOC) begin
            if (off_q[OFS_W-1:0] == start_q) begin
              alloc_blocks_q <= alloc_blocks_q - CNT_W'(1);
              alloc_bytes_q  <= alloc_bytes_q - pow2_bytes(ord_q);
              free_blocks_q  <= free_blocks_q + CNT_W'(1);
              free_bytes_q   <= free_bytes_q + pow2_bytes(ord_q);
              stat_q         <= STAT_DONE;
              cur_av_q       <= ord_q + ORD_W'(1);
              merge_q        <= 1'b1;
              state_q        <= ST_UP_RD;
            end else begin
              stat_q  <= STAT_IGNORED;
              state_q <= ST_FIN;
            end
          end else if (ent_st == NODE_SPLIT && ord_q > MIN_ORD) begin
            ord_q <= ord_dn;
            if (off_q[ord_dn]) begin
              idx_q   <= idx_r;
              start_q <= start_q + half;
            end else begin
              idx_q <= idx_l;
            end
          end else begin
            stat_q  <= STAT_IGNORED;
            state_q <= ST_FIN;
          end
        end
        ST_UP_RD: begin
          state_q <= (idx_q == ROOT) ? ST_FIN : ST_UP_EVAL;
        end
        ST_UP_EVAL: begin
          // merge buddies while both halves are free, then refresh free orders
          if (merge_q && ent_st == NODE_FREE) begin
            free_blocks_q <= free_blocks_q - CNT_W'(1);
            cur_av_q      <= ord_q + ORD_W'(2);
          end else begin
            merge_q  <= 1'b0;
            cur_av_q <= up_max;
          end
          idx_q   <= idx_par;
          ord_q   <= ord_q + ORD_W'(1);
          state_q <= ST_UP_RD;
        end
        ST_FIN: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q            <= 1'b1;
            rsp_o.status           <= stat_q;
            rsp_o.block_address    <= blk_q;
            rsp_o.allocated_bytes  <= alloc_bytes_q;
            rsp_o.free_bytes       <= free_bytes_q;
            rsp_o.allocated_blocks <= alloc_blocks_q;
            rsp_o.free_blocks      <= free_blocks_q;
            state_q                <= ST_IDLE;
          end
        end
        default: state_q <= ST_INIT;
      endcase
    end
  end

  assign rsp_o.valid = out_valid_q;

  // byte totals always cover the whole top block between operations
  a_bytes_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> BYTES_W'(alloc_bytes_q + free_bytes_q) == pow2_bytes(top_q))
    else $error("byte totals do not add up to the top block");

  // walks never read the node they write in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_rd_en_o && mem_wr_en_o |-> mem_rd_addr_o != mem_wr_addr_o)
    else $error("tree read and write hit one node");

  // node index stays inside the heap
  a_idx_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> idx_q != '0)
    else $error("node index is zero");

  // split only above the smallest order
  a_split_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_A_SPLITR |-> ord_q > MIN_ORD)
    else $error("split below smallest block order");
endmodule

// ----- rtl/core/buddy_block_allocator_core.sv -----
// buddy block allocator top level: sequencer plus tree node memory
//
//  channel  dir  handshake      payload
//  req_i    in   valid/ready    command, request_bytes, address
//  rsp_o    out  valid/ready    status, block_address, totals
//  cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i (0 base, 1 pool size)
//
// one transfer in, one result out; an allocate walks the tree down level by level
// and then back up to refresh free orders, a free walks down to the block and back
// up merging buddies; no new request is taken until the result is registered
// reset or a configuration write seeds the root node in the init state
// a stalled result holds the block in its final state until taken
module buddy_block_allocator_core import bba_pkg::*; #(
  parameter int MIN_BLOCK_ORDER = 4,
  parameter int POOL_ORDER_MAX  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  bba_req_if.sink              req_i,
  bba_rsp_if.source            rsp_o
);
  // heap indexed tree, root at 1, one node per block of every order
  localparam int IW = POOL_ORDER_MAX - MIN_BLOCK_ORDER + 1;
  // node word: state and largest free order below, plus one
  localparam int EW = 2 + ORD_W;

  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] rd_data, wr_data;

  bba_ctrl #(
    .MIN_BLOCK_ORDER (MIN_BLOCK_ORDER),
    .POOL_ORDER_MAX  (POOL_ORDER_MAX),
    .IW              (IW),
    .EW              (EW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .req_i         (req_i),
    .rsp_o         (rsp_o),
    .mem_rd_en_o   (rd_en),
    .mem_rd_addr_o (rd_addr),
    .mem_rd_data_i (rd_data),
    .mem_wr_en_o   (wr_en),
    .mem_wr_addr_o (wr_addr),
    .mem_wr_data_o (wr_data)
  );

  // nodes become reachable only after being written, so no clearing pass
  bba_tree_ram #(
    .AW (IW),
    .DW (EW)
  ) u_tree (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );
endmodule
